// ===== rtl/core/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon package
// Result codes, vertex counter sizing and the per-edge status record that
// passes between the edge evaluator and the top level.
// ----------------------------------------------------------------------------
package pip_pkg;

  // Result codes on the location field.
  localparam logic [1:0] LOC_OUTSIDE  = 2'd0;
  localparam logic [1:0] LOC_INSIDE   = 2'd1;
  localparam logic [1:0] LOC_BOUNDARY = 2'd2;

  // Vertex counter saturates at the smallest polygon that has an interior.
  localparam int unsigned CNT_W = 2;
  localparam logic [CNT_W-1:0] CNT_NONE     = 2'd0;
  localparam logic [CNT_W-1:0] CNT_ONE      = 2'd1;
  localparam logic [CNT_W-1:0] MIN_VERTICES = 2'd3;

  // Outcome of one polygon edge against the query point.
  typedef struct packed {
    logic toggle;    // edge crosses the ray: flip inside parity
    logic boundary;  // point lies on the edge or on one of its ends
  } edge_res_t;

endpackage

// ===== rtl/core/pip_in_if.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon request channel
// Valid/ready channel carrying one polygon vertex, the query point and the
// last-vertex mark.
// ----------------------------------------------------------------------------
interface pip_in_if #(
  parameter int unsigned COORD_BITS = 16
) ();

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         last_vertex;

  modport source (
    output valid, vertex_x, vertex_y, point_x, point_y, last_vertex,
    input  ready
  );

  modport sink (
    input  valid, vertex_x, vertex_y, point_x, point_y, last_vertex,
    output ready
  );

endinterface

// ===== rtl/core/pip_out_if.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon result channel
// Valid/ready channel carrying one location code per polygon.
// ----------------------------------------------------------------------------
interface pip_out_if ();

  logic       valid;
  logic       ready;
  logic [1:0] location;

  modport source (
    output valid, location,
    input  ready
  );

  modport sink (
    input  valid, location,
    output ready
  );

endinterface

// ===== rtl/core/pip_edge.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon edge evaluator
// Takes edge a->b relative to the query point, registers the two cross
// product terms and the compare flags, then resolves toggle and boundary.
// ----------------------------------------------------------------------------
module pip_edge #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [COORD_BITS-1:0] ax_i,
  input  logic signed [COORD_BITS-1:0] ay_i,
  input  logic signed [COORD_BITS-1:0] bx_i,
  input  logic signed [COORD_BITS-1:0] by_i,
  input  logic signed [COORD_BITS-1:0] px_i,
  input  logic signed [COORD_BITS-1:0] py_i,
  output pip_pkg::edge_res_t           res_o
);

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned SW = PW + 1;

  logic signed [DW-1:0] dax, day, dbx, dby;
  logic                 dax_neg, dbx_pos;
  logic                 vert_hit_d, cross_y;
  logic                 direct_d, need_cross_d, up_d;
  logic signed [PW-1:0] prod1_d, prod2_d;

  logic signed [PW-1:0] prod1_q, prod2_q;
  logic                 vert_hit_q, direct_q, need_cross_q, up_q;

  logic signed [SW-1:0] cross_val;
  logic                 cross_zero, cross_pos;

  // Coordinates relative to the query point, one bit wider so they are exact.
  assign dax = $signed({ax_i[COORD_BITS-1], ax_i}) - $signed({px_i[COORD_BITS-1], px_i});
  assign day = $signed({ay_i[COORD_BITS-1], ay_i}) - $signed({py_i[COORD_BITS-1], py_i});
  assign dbx = $signed({bx_i[COORD_BITS-1], bx_i}) - $signed({px_i[COORD_BITS-1], px_i});
  assign dby = $signed({by_i[COORD_BITS-1], by_i}) - $signed({py_i[COORD_BITS-1], py_i});

  assign dax_neg = dax[DW-1];
  assign dbx_pos = !dbx[DW-1] && (dbx != '0);

  // Point on end b, or on a horizontal edge through the point.
  assign vert_hit_d = (dby == '0) &&
                      ((dbx == '0) || ((day == '0) && (dbx_pos == dax_neg)));

  // Edge straddles the horizontal line through the point.
  assign cross_y      = day[DW-1] != dby[DW-1];
  assign direct_d     = cross_y && !dax_neg && dbx_pos;
  assign need_cross_d = cross_y && (!dax_neg != dbx_pos);
  assign up_d         = dby > day;

  assign prod1_d = dax * dby;
  assign prod2_d = dbx * day;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod1_q      <= prod1_d;
      prod2_q      <= prod2_d;
      vert_hit_q   <= vert_hit_d;
      direct_q     <= direct_d;
      need_cross_q <= need_cross_d;
      up_q         <= up_d;
    end
  end

  // Sign of the cross product decides the side of the point.
  assign cross_val  = prod1_q - prod2_q;
  assign cross_zero = cross_val == '0;
  assign cross_pos  = !cross_val[SW-1] && !cross_zero;

  always_comb begin
    res_o.boundary = vert_hit_q || (need_cross_q && cross_zero);
    res_o.toggle   = direct_q || (need_cross_q && !cross_zero && (cross_pos == up_q));
  end

endmodule

// ===== rtl/core/point_in_polygon_test_unit.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon test unit
// Streams polygon vertices and reports whether the query point lies outside,
// inside or on the boundary of the polygon.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one vertex per request, in polygon order, plus the query
//   point (sampled only on the first vertex) and a last-vertex mark. Each
//   request after the first tests the edge from the previous vertex; the
//   last request also tests the closing edge back to the first vertex.
//   res_o carries one location code per polygon, on its last vertex:
//   outside, inside or boundary. Fewer than three vertices give outside.
//   Throughput: one vertex per cycle while req_i.ready is high. The result
//   reaches res_o through the input register, product register and result
//   register, in that order.
//   A stalled result holds in the output register while later vertices keep
//   flowing; req_i.ready drops only when every stage holds an item that
//   cannot advance.
//   Reset clears the pipeline valids, the vertex counter and the parity and
//   boundary flags; the first request after reset starts a new polygon.
// ----------------------------------------------------------------------------
module point_in_polygon_test_unit #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pip_in_if.sink    req_i,
  pip_out_if.source res_o
);

  typedef struct packed {
    logic first;   // request opens a polygon: restart parity and boundary
    logic last;    // request closes the polygon: emit a result
    logic cnt_ok;  // polygon has at least three vertices
    logic e1_en;   // edge from previous vertex is live
    logic e2_en;   // closing edge is live
  } stage_ctl_t;

  // Polygon state, updated at request accept.
  logic [pip_pkg::CNT_W-1:0]    seen_q, seen_d, cnt_next;
  logic signed [COORD_BITS-1:0] first_x_q, first_y_q;
  logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;
  logic signed [COORD_BITS-1:0] held_x_q, held_y_q;
  logic signed [COORD_BITS-1:0] cur_px, cur_py, cur_fx, cur_fy;
  logic                         is_first;

  // Input register stage.
  logic                         s1_valid_q;
  stage_ctl_t                   s1_ctl_q, s1_ctl_d;
  logic signed [COORD_BITS-1:0] s1_ax_q, s1_ay_q, s1_vx_q, s1_vy_q;
  logic signed [COORD_BITS-1:0] s1_fx_q, s1_fy_q, s1_px_q, s1_py_q;

  // Product register stage.
  logic                         s2_valid_q;
  stage_ctl_t                   s2_ctl_q;
  pip_pkg::edge_res_t           e1_res, e2_res;

  // Accumulators and result register.
  logic                         parity_q, on_edge_q;
  logic                         par_new, edge_new;
  logic                         out_valid_q;
  logic [1:0]                   location_q, location_d;

  // Handshake chain.
  logic req_fire, out_free, s2_go, s2_free, s1_go, s1_free;

  assign out_free = !out_valid_q || res_o.ready;
  assign s2_go    = s2_valid_q && (!s2_ctl_q.last || out_free);
  assign s2_free  = !s2_valid_q || s2_go;
  assign s1_go    = s1_valid_q && s2_free;
  assign s1_free  = !s1_valid_q || s1_go;
  assign req_fire = req_i.valid && req_i.ready;

  assign req_i.ready    = s1_free;
  assign res_o.valid    = out_valid_q;
  assign res_o.location = location_q;

  // ---- accept: latch point and first vertex, advance the vertex counter ----
  assign is_first = seen_q == pip_pkg::CNT_NONE;
  assign cur_px   = is_first ? req_i.point_x  : held_x_q;
  assign cur_py   = is_first ? req_i.point_y  : held_y_q;
  assign cur_fx   = is_first ? req_i.vertex_x : first_x_q;
  assign cur_fy   = is_first ? req_i.vertex_y : first_y_q;

  always_comb begin
    priority if (is_first) begin
      cnt_next = pip_pkg::CNT_ONE;
    end else if (seen_q == pip_pkg::MIN_VERTICES) begin
      cnt_next = seen_q;
    end else begin
      cnt_next = seen_q + pip_pkg::CNT_ONE;
    end
    // A closed polygon hands over to a fresh one.
    seen_d = req_i.last_vertex ? pip_pkg::CNT_NONE : cnt_next;

    s1_ctl_d.first  = is_first;
    s1_ctl_d.last   = req_i.last_vertex;
    s1_ctl_d.cnt_ok = cnt_next == pip_pkg::MIN_VERTICES;
    s1_ctl_d.e1_en  = !is_first;
    s1_ctl_d.e2_en  = req_i.last_vertex;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= pip_pkg::CNT_NONE;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (req_fire) begin
        seen_q <= seen_d;
      end
      if (s1_free) begin
        s1_valid_q <= req_fire;
      end
      if (s2_free) begin
        s2_valid_q <= s1_go;
      end
    end
  end

  // Polygon coordinates and the input register snapshot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_x_q <= '0;
      first_y_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      held_x_q  <= '0;
      held_y_q  <= '0;
    end else if (req_fire) begin
      first_x_q <= cur_fx;
      first_y_q <= cur_fy;
      held_x_q  <= cur_px;
      held_y_q  <= cur_py;
      prev_x_q  <= req_i.vertex_x;
      prev_y_q  <= req_i.vertex_y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      s1_ctl_q <= s1_ctl_d;
      s1_ax_q  <= prev_x_q;
      s1_ay_q  <= prev_y_q;
      s1_vx_q  <= req_i.vertex_x;
      s1_vy_q  <= req_i.vertex_y;
      s1_fx_q  <= cur_fx;
      s1_fy_q  <= cur_fy;
      s1_px_q  <= cur_px;
      s1_py_q  <= cur_py;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      s2_ctl_q <= s1_ctl_q;
    end
  end

  // ---- edge evaluators: previous->current and current->first ----
  pip_edge #(
    .COORD_BITS (COORD_BITS)
  ) u_edge_prev (
    .clk_i (clk_i),
    .en_i  (s1_go),
    .ax_i  (s1_ax_q),
    .ay_i  (s1_ay_q),
    .bx_i  (s1_vx_q),
    .by_i  (s1_vy_q),
    .px_i  (s1_px_q),
    .py_i  (s1_py_q),
    .res_o (e1_res)
  );

  pip_edge #(
    .COORD_BITS (COORD_BITS)
  ) u_edge_close (
    .clk_i (clk_i),
    .en_i  (s1_go),
    .ax_i  (s1_vx_q),
    .ay_i  (s1_vy_q),
    .bx_i  (s1_fx_q),
    .by_i  (s1_fy_q),
    .px_i  (s1_px_q),
    .py_i  (s1_py_q),
    .res_o (e2_res)
  );

  // ---- accumulate parity and boundary, form the result ----
  always_comb begin
    par_new  = (!s2_ctl_q.first && parity_q)
             ^ (s2_ctl_q.e1_en && e1_res.toggle)
             ^ (s2_ctl_q.e2_en && e2_res.toggle);
    edge_new = (!s2_ctl_q.first && on_edge_q)
             | (s2_ctl_q.e1_en && e1_res.boundary)
             | (s2_ctl_q.e2_en && e2_res.boundary);

    // Boundary wins over parity; short polygons are always outside.
    priority if (!s2_ctl_q.cnt_ok) begin
      location_d = pip_pkg::LOC_OUTSIDE;
    end else if (edge_new) begin
      location_d = pip_pkg::LOC_BOUNDARY;
    end else if (par_new) begin
      location_d = pip_pkg::LOC_INSIDE;
    end else begin
      location_d = pip_pkg::LOC_OUTSIDE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q    <= 1'b0;
      on_edge_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s2_go) begin
        parity_q  <= par_new;
        on_edge_q <= edge_new;
      end
      if (s2_go && s2_ctl_q.last) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_go && s2_ctl_q.last) begin
      location_q <= location_d;
    end
  end

`ifndef NO_ASSERTIONS
  // A closing vertex always restarts the polygon.
  a_last_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && req_i.last_vertex |=> seen_q == pip_pkg::CNT_NONE)
    else $error("vertex counter not cleared after last vertex");

  // Back-pressure reaches the input only when every stage is occupied.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> s1_valid_q && s2_valid_q && out_valid_q)
    else $error("request stalled with a free pipeline stage");

  // Polygons with fewer than three vertices report outside.
  a_short_is_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_go && s2_ctl_q.last && !s2_ctl_q.cnt_ok |=> location_q == pip_pkg::LOC_OUTSIDE)
    else $error("short polygon not reported outside");

  // Only defined location codes leave the block.
  a_location_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> location_q == pip_pkg::LOC_OUTSIDE ||
                    location_q == pip_pkg::LOC_INSIDE ||
                    location_q == pip_pkg::LOC_BOUNDARY)
    else $error("undefined location code on result");
`endif

endmodule

// ===== tb/pip_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon scoreboard
// Tracks the polygon under construction as vertex requests are accepted and
// keeps the location codes that the completed polygons must produce.
// ----------------------------------------------------------------------------
package pip_tb_pkg;

  import pip_pkg::*;

  localparam int unsigned COORD_W = 16;

  typedef logic signed [COORD_W-1:0] coord_t;

  class location_scoreboard;

    coord_t           first_x, first_y;
    coord_t           prev_x, prev_y;
    coord_t           query_x, query_y;
    bit               parity;
    bit               on_boundary;
    logic [CNT_W-1:0] vertex_cnt;
    logic [1:0]       location_q[$];
    int unsigned      results_seen;
    int unsigned      errors;

    function new();
      clear_polygon();
      results_seen = 0;
      errors = 0;
    endfunction

    function void clear_polygon();
      first_x = '0;
      first_y = '0;
      prev_x = '0;
      prev_y = '0;
      query_x = '0;
      query_y = '0;
      parity = 1'b0;
      on_boundary = 1'b0;
      vertex_cnt = CNT_NONE;
    endfunction

    // Sign of the cross product decides the side when the edge straddles
    // the ray origin in x; zero means the point is on the edge.
    function void side_test(longint x0, longint y0, longint x1, longint y1,
                            longint px, longint py);
      longint det;
      det = (x0 - px) * (y1 - py) - (x1 - px) * (y0 - py);
      if (det == 0)
        on_boundary = 1'b1;
      else if ((det > 0) == (y1 > y0))
        parity = ~parity;
    endfunction

    function void walk_edge(coord_t ax, coord_t ay, coord_t bx, coord_t by);
      longint x0, y0, x1, y1, px, py;
      x0 = ax;
      y0 = ay;
      x1 = bx;
      y1 = by;
      px = query_x;
      py = query_y;
      if (y1 == py) begin
        if (x1 == px || (y0 == py && ((x1 > px) == (x0 < px))))
          on_boundary = 1'b1;
      end
      if ((y0 < py) != (y1 < py)) begin
        if (x0 >= px) begin
          if (x1 > px)
            parity = ~parity;
          else
            side_test(x0, y0, x1, y1, px, py);
        end else if (x1 > px) begin
          side_test(x0, y0, x1, y1, px, py);
        end
      end
    endfunction

    function void note_vertex(coord_t vx, coord_t vy, coord_t px, coord_t py,
                              logic is_last);
      logic [1:0] loc;
      if (vertex_cnt == CNT_NONE) begin
        query_x = px;
        query_y = py;
        first_x = vx;
        first_y = vy;
        parity = 1'b0;
        on_boundary = 1'b0;
        vertex_cnt = CNT_ONE;
      end else begin
        walk_edge(prev_x, prev_y, vx, vy);
        if (vertex_cnt < MIN_VERTICES)
          vertex_cnt = vertex_cnt + 1'b1;
      end
      prev_x = vx;
      prev_y = vy;
      if (is_last) begin
        walk_edge(vx, vy, first_x, first_y);
        if (vertex_cnt < MIN_VERTICES)
          loc = LOC_OUTSIDE;
        else if (on_boundary)
          loc = LOC_BOUNDARY;
        else if (parity)
          loc = LOC_INSIDE;
        else
          loc = LOC_OUTSIDE;
        location_q.push_back(loc);
        clear_polygon();
      end
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_location(logic [1:0] got);
      logic [1:0] want;
      results_seen++;
      if (location_q.size() == 0) begin
        report($sformatf("result %0d: location %0d with no polygon outstanding",
                         results_seen, got));
      end else begin
        want = location_q.pop_front();
        if (got !== want)
          report($sformatf("result %0d: location %0d, expected %0d",
                           results_seen, got, want));
      end
    endtask

    function int pending();
      return location_q.size();
    endfunction

  endclass

endpackage

// ===== tb/tb_point_in_polygon_test_unit.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon test unit testbench
// Streams directed and random polygons through the unit with random gaps on
// the request side and random stalls on the result side, predicts each
// polygon's location code and compares every returned code in order.
// ----------------------------------------------------------------------------
module tb_point_in_polygon_test_unit;

  timeunit 1ns;
  timeprecision 1ps;

  import pip_pkg::*;
  import pip_tb_pkg::*;

  localparam int unsigned ITEM_TARGET = 1100;
  localparam int unsigned STALL_LIMIT = 5000;  // cycles without any handshake
  localparam int unsigned LONG_HOLD   = 400;   // result side back-pressure
  localparam int unsigned MAX_VERTS   = 16;
  localparam int          FULL_SPAN   = 32768;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pip_in_if #(.COORD_BITS(COORD_W)) req_if ();
  pip_out_if                        res_if ();

  point_in_polygon_test_unit #(
    .COORD_BITS(COORD_W)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .res_o (res_if)
  );

  always #6 clk_i = ~clk_i;

  location_scoreboard sb;

  // Polygon staging area, filled before a polygon is streamed.
  coord_t      poly_x[MAX_VERTS];
  coord_t      poly_y[MAX_VERTS];
  int unsigned vertices_sent = 0;
  int          send_mode     = 0;  // 0: back to back, 1: wide gaps, 2: rare gaps

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Offer one vertex request after a gap set by send_mode and hold it until accepted.
  task automatic push_vertex(coord_t vx, coord_t vy, coord_t px, coord_t py,
                             bit is_last);
    int gap;
    case (send_mode)
      0: gap = 0;
      1: gap = $urandom_range(0, 19);
      default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
    endcase
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.vertex_x    <= vx;
    req_if.vertex_y    <= vy;
    req_if.point_x     <= px;
    req_if.point_y     <= py;
    req_if.last_vertex <= is_last;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    vertices_sent++;
  endtask

  // Stream the staged polygon; the query point rides on the first vertex,
  // later vertices carry junk there that the unit must ignore.
  task automatic send_polygon(int n, coord_t px, coord_t py);
    coord_t qx, qy;
    for (int i = 0; i < n; i++) begin
      qx = (i == 0) ? px : coord_t'($urandom);
      qy = (i == 0) ? py : coord_t'($urandom);
      push_vertex(poly_x[i], poly_y[i], qx, qy, i == n - 1);
    end
  endtask

  task automatic set_vertex(int idx, int x, int y);
    poly_x[idx] = coord_t'(x);
    poly_y[idx] = coord_t'(y);
  endtask

  task automatic stage_square(int half);
    set_vertex(0, -half, -half);
    set_vertex(1,  half, -half);
    set_vertex(2,  half,  half);
    set_vertex(3, -half,  half);
  endtask

  function automatic coord_t rand_coord(int span);
    int c;
    if (span >= FULL_SPAN)
      return coord_t'($urandom);
    c = $urandom_range(0, 2 * span);
    return coord_t'(c - span);
  endfunction

  // Build one random polygon and pick a query point that often lands on a
  // vertex, an edge or a vertex's scan line, where the corner cases live.
  task automatic random_polygon();
    int     n, span, pick, j, k;
    coord_t x0, x1, y0, y1, t, px, py;
    pick = $urandom_range(0, 9);
    span = (pick < 5) ? 8 : (pick < 8) ? 1000 : FULL_SPAN;
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      // Axis-aligned rectangle, either winding; degenerate ones allowed.
      x0 = rand_coord(span);
      x1 = rand_coord(span);
      y0 = rand_coord(span);
      y1 = rand_coord(span);
      if (x0 > x1) begin
        t = x0; x0 = x1; x1 = t;
      end
      if (y0 > y1) begin
        t = y0; y0 = y1; y1 = t;
      end
      n = 4;
      poly_x[0] = x0; poly_y[0] = y0;
      poly_x[2] = x1; poly_y[2] = y1;
      if ($urandom_range(0, 1)) begin
        poly_x[1] = x1; poly_y[1] = y0;
        poly_x[3] = x0; poly_y[3] = y1;
      end else begin
        poly_x[1] = x0; poly_y[1] = y1;
        poly_x[3] = x1; poly_y[3] = y0;
      end
    end else begin
      if (pick == 3)
        n = $urandom_range(1, 2);
      else if (pick == 9)
        n = $urandom_range(3, MAX_VERTS);
      else
        n = $urandom_range(3, 8);
      for (int i = 0; i < n; i++) begin
        poly_x[i] = rand_coord(span);
        poly_y[i] = rand_coord(span);
      end
    end
    j = $urandom_range(0, n - 1);
    k = (j + 1) % n;
    case ($urandom_range(0, 3))
      0: begin
        px = rand_coord(span);
        py = rand_coord(span);
      end
      1: begin
        px = poly_x[j];
        py = poly_y[j];
      end
      2: begin
        px = coord_t'((int'(poly_x[j]) + int'(poly_x[k])) >>> 1);
        py = coord_t'((int'(poly_y[j]) + int'(poly_y[k])) >>> 1);
      end
      default: begin
        px = rand_coord(span);
        py = poly_y[j];
      end
    endcase
    send_polygon(n, px, py);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    req_if.valid       <= 1'b0;
    req_if.vertex_x    <= '0;
    req_if.vertex_y    <= '0;
    req_if.point_x     <= '0;
    req_if.point_y     <= '0;
    req_if.last_vertex <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Square around the origin: point inside, on a corner, on an edge, and
    // outside on a corner's scan line.
    send_mode = 0;
    stage_square(100);
    send_polygon(4, 0, 0);
    stage_square(100);
    send_polygon(4, 100, 100);
    send_mode = 2;
    stage_square(100);
    send_polygon(4, 0, -100);
    stage_square(100);
    send_polygon(4, 200, 100);

    // Too few vertices: outside even when the point sits on one.
    set_vertex(0, 0, 0);
    set_vertex(1, 10, 10);
    send_polygon(2, 0, 0);
    set_vertex(0, 5, 5);
    send_polygon(1, 5, 5);

    // Full-range triangle: point inside, then on an extreme corner.
    send_mode = 1;
    set_vertex(0, -32768, -32768);
    set_vertex(1,  32767, -32768);
    set_vertex(2,  0,      32767);
    send_polygon(3, 0, 0);
    set_vertex(0, -32768, -32768);
    set_vertex(1,  32767, -32768);
    set_vertex(2,  0,      32767);
    send_polygon(3, 32767, -32768);

    // Random polygons, changing the request gap pattern per polygon.
    while (vertices_sent < ITEM_TARGET) begin
      send_mode = $urandom_range(0, 2);
      random_polygon();
    end
    req_if.valid <= 1'b0;

    // Let the last accepted vertex reach the scoreboard, drain, then allow
    // a few cycles for any stray result.
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random stalls, quiet stretches, and two long hold-offs so
  // the pipeline fills and request ready drops.
  // --------------------------------------------------------------------------
  initial begin
    int stall, n_res, recv_mode;
    n_res = 0;
    recv_mode = 0;
    forever begin
      if (n_res % 10 == 0)
        recv_mode = $urandom_range(0, 2);
      if (n_res == 30 || n_res == 150)
        stall = LONG_HOLD;
      else if (recv_mode == 0)
        stall = 0;
      else if (recv_mode == 1)
        stall = $urandom_range(0, 19);
      else
        stall = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
      // Lower ready only when actually stalling so it never glitches.
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_if.valid) @(posedge clk_i);
      n_res++;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: note accepted vertices, check accepted results.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready)
        sb.note_vertex(req_if.vertex_x, req_if.vertex_y, req_if.point_x,
                       req_if.point_y, req_if.last_vertex);
      if (res_if.valid && res_if.ready)
        sb.check_location(res_if.location);
    end
  end

  // Watchdog: end the run if no handshake happens for too long.
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
rtl/core/pip_pkg.sv
rtl/core/pip_in_if.sv
rtl/core/pip_out_if.sv
rtl/core/pip_edge.sv
rtl/core/point_in_polygon_test_unit.sv
tb/pip_tb_pkg.sv
tb/tb_point_in_polygon_test_unit.sv
